// ===== hdl/qalu_pkg.sv =====
// ============================================================================
// qalu_pkg
// Shared codes and constants for the Q16.16 arithmetic unit.
// ============================================================================
`default_nettype none

package qalu_pkg;

    typedef enum logic [3:0] {
        K_ADD   = 4'd0,
        K_SUB   = 4'd1,
        K_MUL   = 4'd2,
        K_DIV   = 4'd3,
        K_EQ    = 4'd4,
        K_LT    = 4'd5,
        K_GT    = 4'd6,
        K_LE    = 4'd7,
        K_GE    = 4'd8,
        K_FLOOR = 4'd9,
        K_FRAC  = 4'd10,
        K_SIN   = 4'd11,
        K_COS   = 4'd12,
        K_INC   = 4'd13,
        K_DEC   = 4'd14
    } t_kind;

    localparam logic signed [31:0] Q_ONE       = 32'sd65536;
    localparam logic [31:0]        Q_FRAC_MASK = 32'd65535;

    localparam int DIV_QBITS     = 48;
    localparam int DIV_STEP_BITS = 2;
    localparam int DIV_STEPS     = DIV_QBITS / DIV_STEP_BITS;
    localparam int DIV_LAT       = DIV_STEPS + 2;
    localparam int TRIG_LAT      = 11;
    localparam int PAD_LAT       = DIV_LAT - TRIG_LAT;

    localparam logic [31:0] C_6   = 32'd6;
    localparam logic [31:0] C_24  = 32'd24;
    localparam logic [31:0] C_120 = 32'd120;
    localparam logic [31:0] C_720 = 32'd720;

    localparam logic [31:0] RECIP_6   = 32'((64'd1 << 32) / 64'd6);
    localparam logic [31:0] RECIP_24  = 32'((64'd1 << 32) / 64'd24);
    localparam logic [31:0] RECIP_120 = 32'((64'd1 << 32) / 64'd120);
    localparam logic [31:0] RECIP_720 = 32'((64'd1 << 32) / 64'd720);

endpackage

`default_nettype wire

// ===== hdl/qalu_div.sv =====
// ============================================================================
// qalu_div
// Pipelined restoring divider for (a*65536)/b, two quotient bits a stage.
// ============================================================================
`default_nettype none

module qalu_div import qalu_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output logic [31:0]             o_quot,
    output logic                    o_err
);

    typedef struct packed {
        logic [31:0]          rem;
        logic [DIV_QBITS-1:0] dq;
        logic [31:0]          dvs;
        logic                 neg;
        logic                 zero;
    } t_div_st;

    function automatic t_div_st div_step(input t_div_st s);
        t_div_st     o;
        logic [32:0] t;
        o = s;
        for (int i = 0; i < DIV_STEP_BITS; i++) begin
            t    = {o.rem, o.dq[DIV_QBITS-1]};
            o.dq = {o.dq[DIV_QBITS-2:0], 1'b0};
            if (t >= {1'b0, o.dvs}) begin
                t       = t - {1'b0, o.dvs};
                o.dq[0] = 1'b1;
            end
            o.rem = t[31:0];
        end
        return o;
    endfunction

    t_div_st     r_st [0:DIV_STEPS];
    t_div_st     n_st0;
    logic [31:0] r_quot;
    logic        r_err;
    logic [31:0] n_quot;
    logic [31:0] w_ua;
    logic [31:0] w_ub;

    always_comb begin
        w_ua       = i_a[31] ? (~$unsigned(i_a) + 32'd1) : $unsigned(i_a);
        w_ub       = i_b[31] ? (~$unsigned(i_b) + 32'd1) : $unsigned(i_b);
        n_st0.rem  = '0;
        n_st0.dq   = {w_ua, 16'd0};
        n_st0.dvs  = w_ub;
        n_st0.neg  = i_a[31] ^ i_b[31];
        n_st0.zero = (i_b == 32'sd0);
    end

    always_comb begin
        n_quot = r_st[DIV_STEPS].dq[31:0];
        if (r_st[DIV_STEPS].neg) begin
            n_quot = ~n_quot + 32'd1;
        end
        if (r_st[DIV_STEPS].zero) begin
            n_quot = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_st0;
            for (int s = 1; s <= DIV_STEPS; s++) begin
                r_st[s] <= div_step(r_st[s-1]);
            end
            r_quot <= n_quot;
            r_err  <= r_st[DIV_STEPS].zero;
        end
    end

    assign o_quot = r_quot;
    assign o_err  = r_err;

endmodule

`default_nettype wire

// ===== hdl/qalu_trig.sv =====
// ============================================================================
// qalu_trig
// Multiply chain for mul, sin and cos with constant divides and final sums.
// ============================================================================
`default_nettype none

module qalu_trig import qalu_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [3:0]         i_kind,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output logic signed [31:0]      o_value
);

    typedef struct packed {
        logic is_cos;
        logic is_mul;
    } t_trig_ctl;

    function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + (p[63] ? 64'sd65535 : 64'sd0);
        return t[47:16];
    endfunction

    t_trig_ctl          r_ctl [0:9];
    logic signed [31:0] r_a   [0:9];
    logic signed [31:0] r_x2  [1:9];
    logic signed [63:0] r_p1, r_p2, r_p3;
    logic signed [31:0] r_x34, r_x34_d, r_x34_d2, r_x56;
    logic [31:0]        r_ma, r_mb, r_ma_d, r_mb_d, r_qa, r_qb;
    logic               r_sa, r_sb, r_sa_d, r_sb_d, r_sa_d2, r_sb_d2;
    logic [63:0]        r_pa, r_pb;
    logic signed [31:0] r_h, r_h_d, r_h_d2;
    logic signed [31:0] r_value;

    t_trig_ctl          w_ctl;
    logic signed [31:0] w_v1, w_v2;
    logic [31:0]        w_ra, w_rb, w_ca, w_cb;
    logic [31:0]        w_qa0, w_qb0, w_rema, w_remb;
    logic signed [31:0] w_qa_s, w_qb_s, w_sin, w_cos;

    always_comb begin
        w_ctl.is_cos = (i_kind == K_COS);
        w_ctl.is_mul = (i_kind == K_MUL);
        w_v1   = w_ctl.is_mul ? i_b : i_a;
        w_v2   = r_ctl[2].is_cos ? r_x2[2] : r_a[2];
        w_ra   = r_ctl[7].is_cos ? RECIP_24 : RECIP_6;
        w_rb   = r_ctl[7].is_cos ? RECIP_720 : RECIP_120;
        w_ca   = r_ctl[8].is_cos ? C_24 : C_6;
        w_cb   = r_ctl[8].is_cos ? C_720 : C_120;
        w_qa0  = r_pa[63:32];
        w_qb0  = r_pb[63:32];
        w_rema = r_ma_d - 32'(w_qa0 * w_ca);
        w_remb = r_mb_d - 32'(w_qb0 * w_cb);
        w_qa_s = r_sa_d2 ? -$signed(r_qa) : $signed(r_qa);
        w_qb_s = r_sb_d2 ? -$signed(r_qb) : $signed(r_qb);
        w_sin  = r_a[9] - w_qa_s + w_qb_s;
        w_cos  = Q_ONE - r_h_d2 + w_qa_s - w_qb_s;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl[0] <= w_ctl;
            r_a[0]   <= i_a;
            for (int k = 1; k <= 9; k++) begin
                r_ctl[k] <= r_ctl[k-1];
                r_a[k]   <= r_a[k-1];
            end
            for (int k = 2; k <= 9; k++) begin
                r_x2[k] <= r_x2[k-1];
            end
            r_p1     <= i_a * w_v1;
            r_x2[1]  <= qscale(r_p1);
            r_p2     <= r_x2[2] * w_v2;
            r_x34    <= qscale(r_p2);
            r_p3     <= r_x34 * r_x2[4];
            r_x34_d  <= r_x34;
            r_x56    <= qscale(r_p3);
            r_x34_d2 <= r_x34_d;
            r_sa     <= r_x34_d2[31];
            r_sb     <= r_x56[31];
            r_ma     <= r_x34_d2[31] ? (~$unsigned(r_x34_d2) + 32'd1) : $unsigned(r_x34_d2);
            r_mb     <= r_x56[31] ? (~$unsigned(r_x56) + 32'd1) : $unsigned(r_x56);
            r_h      <= $signed(r_x2[6] + {31'd0, r_x2[6][31]}) >>> 1;
            r_pa     <= r_ma * w_ra;
            r_pb     <= r_mb * w_rb;
            r_ma_d   <= r_ma;
            r_mb_d   <= r_mb;
            r_sa_d   <= r_sa;
            r_sb_d   <= r_sb;
            r_h_d    <= r_h;
            r_qa     <= w_qa0 + {31'd0, (w_rema >= w_ca)};
            r_qb     <= w_qb0 + {31'd0, (w_remb >= w_cb)};
            r_sa_d2  <= r_sa_d;
            r_sb_d2  <= r_sb_d;
            r_h_d2   <= r_h_d;
            r_value  <= r_ctl[9].is_mul ? r_x2[9] : (r_ctl[9].is_cos ? w_cos : w_sin);
        end
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

// ===== hdl/q16_16_arithmetic_unit.sv =====
// ============================================================================
// q16_16_arithmetic_unit
// Signed Q16.16 arithmetic unit: wrapping add/sub, multiply, divide,
// compares, floor/frac, inc/dec, Taylor sin/cos.
// ============================================================================
// Usage:
//   Input channel i_valid/o_ready carries i_kind, i_operand_a, i_operand_b.
//   Output channel o_valid/i_ready carries o_value_out, o_compare_true and
//   o_divide_error; exactly one result item per input item, in order.
//   Every operation passes the same register chain from acceptance to o_valid,
//   set by the 24-stage divider (two quotient bits a stage) plus its entry
//   and sign stages and the output register.
//   Throughput is one item per cycle while the receiver takes results.
//   When the receiver stalls, the whole pipeline holds in place and o_ready
//   drops while a result waits unaccepted; nothing is lost or repeated.
//   A synchronous active-low reset clears all valid bits; the pipeline is
//   empty and ready on the first cycle after reset.
// ============================================================================
`default_nettype none

module q16_16_arithmetic_unit import qalu_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [3:0]         i_kind,
    input  wire logic signed [31:0] i_operand_a,
    input  wire logic signed [31:0] i_operand_b,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_value_out,
    output logic                    o_compare_true,
    output logic                    o_divide_error
);

    typedef struct packed {
        logic signed [31:0] val;
        logic               cmp;
    } t_simple;

    logic               w_en;
    logic [DIV_LAT-1:0] r_vld;
    logic               r_ovld;
    logic [3:0]         r_kind [0:DIV_LAT-1];
    t_simple            r_simple [0:DIV_LAT-1];
    logic signed [31:0] r_tpad [0:PAD_LAT-1];
    t_simple            n_simple;
    logic [31:0]        w_quot;
    logic               w_err;
    logic signed [31:0] w_trig;
    logic signed [31:0] r_val, n_val;
    logic               r_cmp, n_cmp, r_err, n_err;

    assign w_en    = !r_ovld || i_ready;
    assign o_ready = w_en;

    qalu_div u_div (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_a    (i_operand_a),
        .i_b    (i_operand_b),
        .o_quot (w_quot),
        .o_err  (w_err)
    );

    qalu_trig u_trig (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_kind  (i_kind),
        .i_a     (i_operand_a),
        .i_b     (i_operand_b),
        .o_value (w_trig)
    );

    always_comb begin
        n_simple = '0;
        case (i_kind)
            K_ADD:   n_simple.val = i_operand_a + i_operand_b;
            K_SUB:   n_simple.val = i_operand_a - i_operand_b;
            K_EQ:    n_simple.cmp = (i_operand_a == i_operand_b);
            K_LT:    n_simple.cmp = (i_operand_a < i_operand_b);
            K_GT:    n_simple.cmp = (i_operand_a > i_operand_b);
            K_LE:    n_simple.cmp = (i_operand_a <= i_operand_b);
            K_GE:    n_simple.cmp = (i_operand_a >= i_operand_b);
            K_FLOOR: n_simple.val = $signed($unsigned(i_operand_a) & ~Q_FRAC_MASK);
            K_FRAC:  n_simple.val = $signed($unsigned(i_operand_a) & Q_FRAC_MASK);
            K_INC:   n_simple.val = i_operand_a + Q_ONE;
            K_DEC:   n_simple.val = i_operand_a - Q_ONE;
            default: n_simple = '0;
        endcase
    end

    always_comb begin
        n_val = r_simple[DIV_LAT-1].val;
        n_cmp = r_simple[DIV_LAT-1].cmp;
        n_err = 1'b0;
        case (r_kind[DIV_LAT-1])
            K_DIV: begin
                n_val = $signed(w_quot);
                n_err = w_err;
            end
            K_MUL, K_SIN, K_COS: begin
                n_val = r_tpad[PAD_LAT-1];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_vld  <= {r_vld[DIV_LAT-2:0], i_valid};
            r_ovld <= r_vld[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_kind[0]   <= i_kind;
            r_simple[0] <= n_simple;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_kind[k]   <= r_kind[k-1];
                r_simple[k] <= r_simple[k-1];
            end
            r_tpad[0] <= w_trig;
            for (int k = 1; k < PAD_LAT; k++) begin
                r_tpad[k] <= r_tpad[k-1];
            end
            r_val <= n_val;
            r_cmp <= n_cmp;
            r_err <= n_err;
        end
    end

    assign o_valid        = r_ovld;
    assign o_value_out    = r_val;
    assign o_compare_true = r_cmp;
    assign o_divide_error = r_err;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_error |-> o_value_out == 32'sd0)
        else $error("divide error with non-zero value");
    a_err_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_compare_true && o_divide_error))
        else $error("compare and divide error both set");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld) && r_ovld)
        else $error("pipeline moved while stalled");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && !i_ready |-> !o_ready)
        else $error("ready while result waits");
`endif

endmodule

`default_nettype wire

// ===== sim/q16_16_arithmetic_unit_tb.sv =====
// ============================================================================
// q16_16_arithmetic_unit_tb
// Self-checking bench for the Q16.16 arithmetic unit: a directed table of
// edge cases followed by random items, every result compared in order against
// a behavioural predictor, with random idling on both handshakes.
// ============================================================================
`default_nettype none

module q16_16_arithmetic_unit_tb import qalu_pkg::*; ();

    localparam int LATENCY = 27;
    localparam int N_RANDOM = 800;

    typedef struct packed {
        logic signed [31:0] value;
        logic               cmp;
        logic               err;
    } t_result;

    typedef struct {
        logic [3:0]         kind;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic               known;
        t_result            res;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [3:0]         i_kind;
    logic signed [31:0] i_operand_a;
    logic signed [31:0] i_operand_b;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_value_out;
    logic               o_compare_true;
    logic               o_divide_error;

    t_result expected_q[$];
    int      n_errors;
    bit      no_idle;

    q16_16_arithmetic_unit u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] q_mul(logic signed [31:0] x,
                                                 logic signed [31:0] y);
        logic signed [63:0] p;
        p = 64'(x) * 64'(y);
        return 32'(p / 64'sd65536);
    endfunction

    function automatic t_result alu_result(logic [3:0] kind, logic signed [31:0] a,
                                           logic signed [31:0] b);
        t_result r;
        logic signed [31:0] x2, x3, x4, x5, x6;
        logic signed [63:0] n;
        r = '0;
        case (kind)
            K_ADD:   r.value = a + b;
            K_SUB:   r.value = a - b;
            K_MUL:   r.value = q_mul(a, b);
            K_DIV: begin
                if (b == 0) begin
                    r.err = 1'b1;
                end else begin
                    n = 64'(a) * 64'sd65536;
                    r.value = 32'(n / 64'(b));
                end
            end
            K_EQ:    r.cmp = (a == b);
            K_LT:    r.cmp = (a < b);
            K_GT:    r.cmp = (a > b);
            K_LE:    r.cmp = (a <= b);
            K_GE:    r.cmp = (a >= b);
            K_FLOOR: r.value = a & ~Q_FRAC_MASK;
            K_FRAC:  r.value = a & Q_FRAC_MASK;
            K_SIN: begin
                x2 = q_mul(a, a);
                x3 = q_mul(x2, a);
                x5 = q_mul(x3, x2);
                r.value = a - x3 / 32'sd6 + x5 / 32'sd120;
            end
            K_COS: begin
                x2 = q_mul(a, a);
                x4 = q_mul(x2, x2);
                x6 = q_mul(x4, x2);
                r.value = Q_ONE - x2 / 32'sd2 + x4 / 32'sd24 - x6 / 32'sd720;
            end
            K_INC:   r.value = a + Q_ONE;
            K_DEC:   r.value = a - Q_ONE;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff - $urandom_range(0, 3);
            1: return 32'sh80000000 + $urandom_range(0, 3);
            2: return $signed($urandom_range(0, 8)) - 4;
            3: return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(logic [3:0] kind, logic signed [31:0] a,
                             logic signed [31:0] b);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (!o_ready);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            expected_q.push_back(alu_result(i_kind, i_operand_a, i_operand_b));
        end
    end

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result item value_out=%h", o_value_out);
                n_errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_value_out !== e.value) begin
                    $error("value_out expected %h actual %h", e.value, o_value_out);
                    n_errors++;
                end
                if (o_compare_true !== e.cmp) begin
                    $error("compare_true expected %b actual %b", e.cmp, o_compare_true);
                    n_errors++;
                end
                if (o_divide_error !== e.err) begin
                    $error("divide_error expected %b actual %b", e.err, o_divide_error);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        int burst;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (burst > 0) begin
                burst--;
                i_ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(0, 8);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_row rows[$];
        t_result got;
        logic [3:0] k;
        int wait_cycles;
        n_errors    = 0;
        no_idle     = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_kind      = '0;
        i_operand_a = '0;
        i_operand_b = '0;

        rows = '{
            '{K_DIV, 32'sh00010000, 32'sh0, 1'b1, '{32'sh0, 1'b0, 1'b1}},
            '{K_DIV, 32'sh80000000, 32'sh0, 1'b1, '{32'sh0, 1'b0, 1'b1}},
            '{K_ADD, 32'sh7fffffff, 32'sh1, 1'b1, '{32'sh80000000, 1'b0, 1'b0}},
            '{K_SUB, 32'sh80000000, 32'sh1, 1'b1, '{32'sh7fffffff, 1'b0, 1'b0}},
            '{K_INC, 32'sh7fffffff, 32'sh0, 1'b1, '{32'sh8000ffff, 1'b0, 1'b0}},
            '{K_DEC, 32'sh80000000, 32'sh0, 1'b1, '{32'sh7fff0000, 1'b0, 1'b0}},
            '{K_EQ, 32'sh80000000, 32'sh80000000, 1'b1, '{32'sh0, 1'b1, 1'b0}},
            '{K_LT, 32'sh80000000, 32'sh7fffffff, 1'b1, '{32'sh0, 1'b1, 1'b0}},
            '{K_GT, 32'sh80000000, 32'sh7fffffff, 1'b1, '{32'sh0, 1'b0, 1'b0}},
            '{K_LE, 32'sh5, 32'sh5, 1'b1, '{32'sh0, 1'b1, 1'b0}},
            '{K_GE, 32'sh4, 32'sh5, 1'b1, '{32'sh0, 1'b0, 1'b0}},
            '{K_FLOOR, 32'shffffffff, 32'sh0, 1'b1, '{32'shffff0000, 1'b0, 1'b0}},
            '{K_FRAC, 32'shffffffff, 32'sh0, 1'b1, '{32'sh0000ffff, 1'b0, 1'b0}},
            '{K_COS, 32'sh0, 32'sh0, 1'b1, '{32'sh00010000, 1'b0, 1'b0}},
            '{4'd15, 32'shffffffff, 32'shffffffff, 1'b1, '{32'sh0, 1'b0, 1'b0}},
            '{K_MUL, 32'sh7fffffff, 32'sh7fffffff, 1'b0, '0},
            '{K_MUL, 32'sh80000000, 32'sh7fffffff, 1'b0, '0},
            '{K_MUL, 32'shffff8000, 32'sh00008000, 1'b0, '0},
            '{K_DIV, 32'sh80000000, 32'shffffffff, 1'b0, '0},
            '{K_DIV, 32'shfffffff0, 32'sh00030000, 1'b0, '0},
            '{K_SIN, 32'sh0001921f, 32'sh0, 1'b0, '0},
            '{K_SIN, 32'sh7fffffff, 32'sh0, 1'b0, '0},
            '{K_SIN, 32'sh80000000, 32'sh0, 1'b0, '0},
            '{K_COS, 32'sh00032440, 32'sh0, 1'b0, '0},
            '{K_COS, 32'sh80000000, 32'sh0, 1'b0, '0}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].known) begin
                got = alu_result(rows[i].kind, rows[i].a, rows[i].b);
                if (got !== rows[i].res) begin
                    $error("table row %0d expected %h predicted %h", i, rows[i].res, got);
                    n_errors++;
                end
            end
            send_item(rows[i].kind, rows[i].a, rows[i].b);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                i_valid <= 1'b0;
                while (expected_q.size() != 0) @(posedge i_clk);
            end
            if (n == N_RANDOM - 150) no_idle = 1'b1;
            k = ($urandom_range(0, 30) == 0) ? 4'd15 : 4'($urandom_range(0, 14));
            send_item(k, rand_operand(), ($urandom_range(0, 9) == 0) ? 32'sh0
                                                                   : rand_operand());
        end
        i_valid <= 1'b0;

        wait_cycles = 0;
        while (expected_q.size() != 0 && wait_cycles < 10000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (2 * LATENCY) @(posedge i_clk);
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== q16_16_arithmetic_unit.f =====
hdl/qalu_pkg.sv
hdl/qalu_div.sv
hdl/qalu_trig.sv
hdl/q16_16_arithmetic_unit.sv
sim/q16_16_arithmetic_unit_tb.sv
